>>> rtl/jpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus permutation generator package
// Shared widths, register indexes and the result record.
// ----------------------------------------------------------------------------
package jpg_pkg;

   parameter int PERSON_W       = 11;
   parameter int CFG_W          = 11;
   parameter int MAX_PEOPLE_DEF = 1024;

   typedef enum logic [0:0] {
      CSR_CIRCLE_SIZE = 1'b0,
      CSR_STEP_COUNT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                valid;
      logic [PERSON_W-1:0] person;
      logic                round_done;
   } result_type;

endpackage

>>> rtl/jpg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module jpg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/jpg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus ring controller
// Reloads the ring queue, rotates it one entry per cycle and removes the front.
// ----------------------------------------------------------------------------
module jpg_ctrl #(
   parameter int MAX_PEOPLE = jpg_pkg::MAX_PEOPLE_DEF,
   localparam int PTR_W = $clog2(MAX_PEOPLE),
   localparam int CNT_W = $clog2(MAX_PEOPLE + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         restart,
   input  logic [jpg_pkg::CFG_W-1:0]    circle_size,
   input  logic [jpg_pkg::CFG_W-1:0]    step_count,
   input  logic                         res_free,
   output logic                         idle,
   output jpg_pkg::result_type          result,
   output logic                         ram_we,
   output logic [PTR_W-1:0]             ram_waddr,
   output logic [jpg_pkg::PERSON_W-1:0] ram_wdata,
   output logic                         ram_re,
   output logic [PTR_W-1:0]             ram_raddr,
   input  logic [jpg_pkg::PERSON_W-1:0] ram_rdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RELOAD,
      ST_START,
      ST_MOVE,
      ST_FETCH,
      ST_WAIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [PTR_W-1:0]             front_ff, front_in;
   logic [CNT_W-1:0]             left_ff, left_in;
   logic                         pend_ff, pend_in;
   logic [PTR_W-1:0]             idx_ff, idx_in;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic [jpg_pkg::CFG_W-1:0]    mcnt_ff, mcnt_in;
   logic                         wr_pend_ff, wr_pend_in;
   logic [PTR_W-1:0]             wr_addr_ff, wr_addr_in;
   logic                         fwd_hit_ff, fwd_hit_in;
   logic [jpg_pkg::PERSON_W-1:0] fwd_data_ff, fwd_data_in;
   jpg_pkg::result_type          result_ff, result_in;

   logic [jpg_pkg::PERSON_W-1:0] rd_data;
   logic [PTR_W-1:0]             front_inc;
   logic [31:0]                  back_sum;
   logic [PTR_W-1:0]             back_addr;
   logic [CNT_W-1:0]             n_sat;
   logic [jpg_pkg::CFG_W-1:0]    moves;

   always_comb begin
      rd_data   = fwd_hit_ff ? fwd_data_ff : ram_rdata;
      front_inc = (32'(front_ff) == MAX_PEOPLE - 1) ? '0 : front_ff + PTR_W'(1);
      back_sum  = 32'(front_ff) + 32'(left_ff);
      back_addr = (back_sum >= MAX_PEOPLE) ? PTR_W'(back_sum - MAX_PEOPLE)
                                           : PTR_W'(back_sum);
      if (circle_size == '0) begin
         n_sat = CNT_W'(1);
      end else if (32'(circle_size) > MAX_PEOPLE) begin
         n_sat = CNT_W'(MAX_PEOPLE);
      end else begin
         n_sat = CNT_W'(circle_size);
      end
      moves = (step_count == '0) ? '0 : step_count - jpg_pkg::CFG_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      left_in      = left_ff;
      pend_in      = pend_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      mcnt_in      = mcnt_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      fwd_hit_in   = fwd_hit_ff;
      fwd_data_in  = fwd_data_ff;
      result_in    = result_ff;
      result_in.valid = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = front_ff;

      if (state_ff == ST_RELOAD) begin
         ram_we    = 1'b1;
         ram_waddr = idx_ff;
         ram_wdata = jpg_pkg::PERSON_W'(32'(idx_ff) + 1);
      end else begin
         ram_we    = wr_pend_ff;
         ram_waddr = wr_addr_ff;
         ram_wdata = rd_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (restart || pend_ff || left_ff == '0) begin
                  n_in     = n_sat;
                  idx_in   = '0;
                  state_in = ST_RELOAD;
               end else begin
                  state_in = ST_START;
               end
            end
         end
         ST_RELOAD: begin
            idx_in = idx_ff + PTR_W'(1);
            if (CNT_W'(idx_ff) == n_ff - CNT_W'(1)) begin
               front_in = '0;
               left_in  = n_ff;
               pend_in  = 1'b0;
               state_in = ST_START;
            end
         end
         ST_START: begin
            mcnt_in  = moves;
            state_in = (moves == '0) ? ST_FETCH : ST_MOVE;
         end
         ST_MOVE: begin
            ram_re     = 1'b1;
            wr_pend_in = 1'b1;
            wr_addr_in = back_addr;
            front_in   = front_inc;
            mcnt_in    = mcnt_ff - jpg_pkg::CFG_W'(1);
            if (mcnt_ff == jpg_pkg::CFG_W'(1)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            ram_re   = 1'b1;
            front_in = front_inc;
            left_in  = left_ff - CNT_W'(1);
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (res_free) begin
               result_in.valid      = 1'b1;
               result_in.person     = rd_data;
               result_in.round_done = (left_ff == '0);
               if (left_ff == '0) begin
                  pend_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ram_re) begin
         fwd_hit_in  = ram_we && (ram_waddr == ram_raddr);
         fwd_data_in = ram_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         front_ff        <= '0;
         left_ff         <= '0;
         pend_ff         <= 1'b1;
         wr_pend_ff      <= 1'b0;
         fwd_hit_ff      <= 1'b0;
         result_ff.valid <= 1'b0;
      end else begin
         state_ff        <= state_in;
         front_ff        <= front_in;
         left_ff         <= left_in;
         pend_ff         <= pend_in;
         wr_pend_ff      <= wr_pend_in;
         fwd_hit_ff      <= fwd_hit_in;
         result_ff.valid <= result_in.valid;
      end
      idx_ff               <= idx_in;
      n_ff                 <= n_in;
      mcnt_ff              <= mcnt_in;
      wr_addr_ff           <= wr_addr_in;
      fwd_data_ff          <= fwd_data_in;
      result_ff.person     <= result_in.person;
      result_ff.round_done <= result_in.round_done;
   end

   assign idle   = (state_ff == ST_IDLE);
   assign result = result_ff;

   a_left_bound: assert property (@(posedge clock) disable iff (reset)
      32'(left_ff) <= MAX_PEOPLE)
      else $error("people count exceeds ring depth");

   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      32'(front_ff) < MAX_PEOPLE)
      else $error("front pointer outside ring");

   a_no_move_during_reload: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == ST_RELOAD && wr_pend_ff))
      else $error("rotation write overlaps reload");

   a_done_sets_reload: assert property (@(posedge clock) disable iff (reset)
      result_ff.valid && result_ff.round_done |-> pend_ff)
      else $error("finished round did not schedule a reload");

endmodule

>>> rtl/josephus_permutation_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Josephus permutation generator
// Reports the (N,K) Josephus elimination order, one person per request.
// ----------------------------------------------------------------------------
// Usage: each request on req_ removes one person from the circle and returns
// that person's number on rsp_; rsp_tlast marks the removal that empties the
// circle. Setting the restart bit of a request starts a new round first.
// The circle size N and step K are written through the csr_ port; the user
// must do so only while the block is idle (not enforced). A new K applies
// at the next request, a new N at the next reload of the circle.
// A request that continues a round moves the ring memory one queue entry
// per cycle for the K - 1 rotations and then reads the front entry. A
// request that reloads the circle first rewrites 1..N into the memory.
// One request is in work at a time; req_tready is high whenever the
// sequencer is idle, even while a response still waits in the output stage.
// Reset clears the control state and schedules a reload for the first
// request; the memory contents are not cleared. When rsp_tready is low, the
// response is held and a finished next request waits until it drains.
// ----------------------------------------------------------------------------
module josephus_permutation_generator #(
   parameter int MAX_PEOPLE = jpg_pkg::MAX_PEOPLE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [0] restart
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [15:0]               rsp_tdata,   // [10:0] removed_person
   output logic                      rsp_tlast,
   input  logic                      csr_wr_en,
   input  logic [0:0]                csr_index,
   input  logic [jpg_pkg::CFG_W-1:0] csr_wr_data
);

   localparam int PTR_W = $clog2(MAX_PEOPLE);

   logic [jpg_pkg::CFG_W-1:0]    circle_size_ff;
   logic [jpg_pkg::CFG_W-1:0]    step_count_ff;
   logic                         rsp_valid_ff;
   logic [jpg_pkg::PERSON_W-1:0] rsp_person_ff;
   logic                         rsp_last_ff;

   logic                         idle;
   logic                         res_free;
   jpg_pkg::result_type          result;
   logic                         ram_we;
   logic [PTR_W-1:0]             ram_waddr;
   logic [jpg_pkg::PERSON_W-1:0] ram_wdata;
   logic                         ram_re;
   logic [PTR_W-1:0]             ram_raddr;
   logic [jpg_pkg::PERSON_W-1:0] ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         circle_size_ff <= jpg_pkg::CFG_W'(1);
         step_count_ff  <= jpg_pkg::CFG_W'(1);
      end else if (csr_wr_en) begin
         case (csr_index)
            jpg_pkg::CSR_CIRCLE_SIZE: begin
               circle_size_ff <= csr_wr_data;
            end
            jpg_pkg::CSR_STEP_COUNT: begin
               step_count_ff <= csr_wr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (result.valid) begin
         rsp_person_ff <= result.person;
         rsp_last_ff   <= result.round_done;
      end
   end

   assign res_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - jpg_pkg::PERSON_W){1'b0}}, rsp_person_ff};
   assign rsp_tlast  = rsp_last_ff;

   jpg_ctrl #(
      .MAX_PEOPLE(MAX_PEOPLE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (req_tvalid && req_tready),
      .restart    (req_tdata[0]),
      .circle_size(circle_size_ff),
      .step_count (step_count_ff),
      .res_free   (res_free),
      .idle       (idle),
      .result     (result),
      .ram_we     (ram_we),
      .ram_waddr  (ram_waddr),
      .ram_wdata  (ram_wdata),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ram_rdata  (ram_rdata)
   );

   jpg_ram #(
      .WIDTH(jpg_pkg::PERSON_W),
      .DEPTH(MAX_PEOPLE)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

endmodule
